// ----- rtl/assert_macros.svh -----
// Assertion macros used by the lexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define TLEX_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define TLEX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/tlex_pkg.sv -----
// Types and constants for the text token lexer.
`timescale 1ns / 1ps

package tlex_pkg;

  localparam int MODE_W    = 3;
  localparam int MASK_W    = 64;
  localparam int CFG_IDX_W = 1;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W     = 2;
  localparam int CNT_W     = 3;

  // Lexer modes
  localparam logic [MODE_W-1:0] MODE_BETWEEN    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WORD       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STRING     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LINE       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BLOCK      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LINE_MARK  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_BLOCK_MARK = 3'd6;
  localparam logic [MODE_W-1:0] MODE_ESC_QUOTE  = 3'd7;

  localparam logic [1:0] ROLE_SKIP    = 2'd0;
  localparam logic [1:0] ROLE_CONTENT = 2'd1;
  localparam logic [1:0] ROLE_QUOTE   = 2'd2;

  localparam logic [1:0] KIND_WORD   = 2'd0;
  localparam logic [1:0] KIND_STRING = 2'd1;
  localparam logic [1:0] KIND_PUNCT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_HIGH = 1'b1;

  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] role;
    logic [1:0] token_kind;
    logic       token_start;
    logic       token_end;
    logic       last_of_run;
  } tok_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [7:0]        held_byte;
    logic              held_valid;
    logic              star_seen;
  } lex_state_t;

  typedef struct packed {
    tok_t       res0;
    tok_t       res1;
    logic       v0;
    logic       v1;
    lex_state_t state;
  } step_t;

endpackage

// ----- rtl/tlex_step.sv -----
// Per-item lexer step: classifies the held byte and, at end of text, the new byte.
`timescale 1ns / 1ps

module tlex_step (
  input  tlex_pkg::lex_state_t    cur,
  input  tlex_pkg::text_t         item,
  input  logic [2*tlex_pkg::MASK_W-1:0] mask,
  output tlex_pkg::step_t         step
);

  typedef struct packed {
    logic [tlex_pkg::MODE_W-1:0] mode;
    logic                        star;
    tlex_pkg::tok_t              res;
  } cls_t;

  function automatic logic word_char(logic [7:0] b, logic [2*tlex_pkg::MASK_W-1:0] m);
    logic alnum;
    alnum = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
            (b >= 8'h30 && b <= 8'h39);
    return alnum || (b != 8'd0 && !b[7] && m[b[6:0]]);
  endfunction

  function automatic cls_t classify(logic [tlex_pkg::MODE_W-1:0] mode, logic star,
                                    logic [7:0] b, logic [7:0] n,
                                    logic [2*tlex_pkg::MASK_W-1:0] m);
    cls_t c;
    logic more;
    logic str_end;
    c            = '0;
    c.mode       = mode;
    c.star       = star;
    c.res.out_byte = b;
    str_end      = (n == 8'd0);
    more         = word_char(n, m);
    if (b == 8'd0) begin
      c.mode = tlex_pkg::MODE_BETWEEN;
      c.star = 1'b0;
    end else begin
      unique case (mode)
        tlex_pkg::MODE_BETWEEN: begin
          if (b <= tlex_pkg::CH_SPACE) begin
            c.mode = mode;
          end else if (b == tlex_pkg::CH_SLASH && n == tlex_pkg::CH_SLASH) begin
            c.mode = tlex_pkg::MODE_LINE_MARK;
          end else if (b == tlex_pkg::CH_SLASH && n == tlex_pkg::CH_STAR) begin
            c.mode = tlex_pkg::MODE_BLOCK_MARK;
          end else if (b == tlex_pkg::CH_QUOTE) begin
            c.mode               = tlex_pkg::MODE_STRING;
            c.res.role           = tlex_pkg::ROLE_QUOTE;
            c.res.token_kind     = tlex_pkg::KIND_STRING;
            c.res.token_start    = 1'b1;
            c.res.token_end      = str_end;
          end else if (word_char(b, m)) begin
            c.mode               = more ? tlex_pkg::MODE_WORD : tlex_pkg::MODE_BETWEEN;
            c.res.role           = tlex_pkg::ROLE_CONTENT;
            c.res.token_kind     = tlex_pkg::KIND_WORD;
            c.res.token_start    = 1'b1;
            c.res.token_end      = !more;
          end else begin
            c.res.role           = tlex_pkg::ROLE_CONTENT;
            c.res.token_kind     = tlex_pkg::KIND_PUNCT;
            c.res.token_start    = 1'b1;
            c.res.token_end      = 1'b1;
          end
        end
        tlex_pkg::MODE_WORD: begin
          c.mode            = more ? tlex_pkg::MODE_WORD : tlex_pkg::MODE_BETWEEN;
          c.res.role        = tlex_pkg::ROLE_CONTENT;
          c.res.token_kind  = tlex_pkg::KIND_WORD;
          c.res.token_end   = !more;
        end
        tlex_pkg::MODE_STRING: begin
          c.res.token_kind = tlex_pkg::KIND_STRING;
          if (b == tlex_pkg::CH_QUOTE) begin
            c.mode          = tlex_pkg::MODE_BETWEEN;
            c.res.role      = tlex_pkg::ROLE_QUOTE;
            c.res.token_end = 1'b1;
          end else if (b == tlex_pkg::CH_BACKSLASH && n == tlex_pkg::CH_QUOTE) begin
            c.mode          = tlex_pkg::MODE_ESC_QUOTE;
            c.res.role      = tlex_pkg::ROLE_CONTENT;
          end else begin
            c.res.role      = tlex_pkg::ROLE_CONTENT;
            c.res.token_end = str_end;
          end
        end
        tlex_pkg::MODE_ESC_QUOTE: begin
          c.mode            = tlex_pkg::MODE_STRING;
          c.res.role        = tlex_pkg::ROLE_CONTENT;
          c.res.token_kind  = tlex_pkg::KIND_STRING;
          c.res.token_end   = str_end;
        end
        tlex_pkg::MODE_LINE: begin
          if (b == tlex_pkg::CH_NEWLINE) c.mode = tlex_pkg::MODE_BETWEEN;
        end
        tlex_pkg::MODE_BLOCK: begin
          if (star) begin
            c.star = 1'b0;
            c.mode = tlex_pkg::MODE_BETWEEN;
          end else if (b == tlex_pkg::CH_STAR && n == tlex_pkg::CH_SLASH) begin
            c.star = 1'b1;
          end
        end
        tlex_pkg::MODE_LINE_MARK: c.mode = tlex_pkg::MODE_LINE;
        tlex_pkg::MODE_BLOCK_MARK: c.mode = tlex_pkg::MODE_BLOCK;
        default: c.mode = tlex_pkg::MODE_BETWEEN;
      endcase
    end
    return c;
  endfunction

  cls_t                        c0;
  cls_t                        c1;
  logic [tlex_pkg::MODE_W-1:0] mode_a;
  logic                        star_a;

  always_comb begin
    c0     = classify(cur.mode, cur.star_seen, cur.held_byte, item.text_byte, mask);
    mode_a = cur.held_valid ? c0.mode : cur.mode;
    star_a = cur.held_valid ? c0.star : cur.star_seen;
    // flushed byte sees a zero byte as lookahead
    c1     = classify(mode_a, star_a, item.text_byte, 8'd0, mask);

    step                  = '0;
    step.res0             = c0.res;
    step.res0.last_of_run = !item.end_of_text;
    step.res1             = c1.res;
    step.res1.last_of_run = 1'b1;
    step.v0               = cur.held_valid;
    step.v1               = item.end_of_text;
    if (item.end_of_text) begin
      step.state            = '0;
      step.state.mode       = tlex_pkg::MODE_BETWEEN;
    end else begin
      step.state.mode       = mode_a;
      step.state.held_byte  = item.text_byte;
      step.state.held_valid = 1'b1;
      step.state.star_seen  = star_a;
    end
  end

endmodule

// ----- rtl/text_token_lexer_core.sv -----
// Top level of the text token lexer: input register, lexer state, result queue.
// A byte's result enters the result queue when the following byte leaves the input register;
//   an end-of-text byte's own result enters it when that byte leaves the input register.
// Throughput: one byte per cycle while the queue has room for two results; an end-of-text
//   item with a held byte makes two results, which the single output port drains one at a time.
// Reset (rst, synchronous): lexer state, input valid, queue pointers and count, and both mask registers clear to zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_token_lexer_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               text_valid,
  output logic                               text_ready,
  input  tlex_pkg::text_t                    text_data,
  output logic                               tok_valid,
  input  logic                               tok_ready,
  output tlex_pkg::tok_t                     tok_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tlex_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlex_pkg::MASK_W-1:0]        cfg_data
);

  logic [tlex_pkg::MASK_W-1:0] allowed_low;
  logic [tlex_pkg::MASK_W-1:0] allowed_high;

  logic                 in_valid;
  tlex_pkg::text_t      in_item;
  tlex_pkg::lex_state_t state;
  tlex_pkg::step_t      step;

  tlex_pkg::tok_t               queue [tlex_pkg::FIFO_DEPTH];
  logic [tlex_pkg::PTR_W-1:0]   wptr;
  logic [tlex_pkg::PTR_W-1:0]   rptr;
  logic [tlex_pkg::CNT_W-1:0]   count;
  logic [tlex_pkg::CNT_W-1:0]   count_next;

  logic           fire;
  logic           pop;
  logic [1:0]     push_n;
  tlex_pkg::tok_t push_a;
  logic           eot_fire;
  logic           state_idle;

  tlex_step u_step (
    .cur  (state),
    .item (in_item),
    .mask ({allowed_high, allowed_low}),
    .step (step)
  );

  // room for two results keeps the worst item from overflowing the queue
  assign fire       = in_valid && (count <= tlex_pkg::CNT_W'(tlex_pkg::FIFO_DEPTH - 2));
  assign text_ready = !in_valid || fire;
  assign cfg_ready  = 1'b1;
  assign tok_valid  = (count != '0);
  assign tok_data   = queue[rptr];
  assign pop        = tok_valid && tok_ready;
  assign push_n     = fire ? ({1'b0, step.v0} + {1'b0, step.v1}) : 2'd0;
  assign push_a     = step.v0 ? step.res0 : step.res1;
  assign count_next = count + tlex_pkg::CNT_W'(push_n) - tlex_pkg::CNT_W'(pop);
  assign eot_fire   = fire && in_item.end_of_text;
  assign state_idle = (state.mode == tlex_pkg::MODE_BETWEEN) && !state.held_valid &&
                      !state.star_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      allowed_low  <= '0;
      allowed_high <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tlex_pkg::CFG_ALLOWED_LOW:  allowed_low  <= cfg_data;
        tlex_pkg::CFG_ALLOWED_HIGH: allowed_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text_ready) begin
      in_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_ready && text_valid) in_item <= text_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= step.state;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) queue[wptr] <= push_a;
    if (push_n == 2'd2) queue[wptr + tlex_pkg::PTR_W'(1)] <= step.res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + tlex_pkg::PTR_W'(push_n);
      rptr  <= rptr + tlex_pkg::PTR_W'(pop);
      count <= count_next;
    end
  end

  `TLEX_ASSERT(a_queue_bound, clk, rst, count <= tlex_pkg::CNT_W'(tlex_pkg::FIFO_DEPTH), "result queue overflow")
  `TLEX_ASSERT(a_eot_clears, clk, rst, eot_fire |=> state_idle, "state not cleared after end of text")
  `TLEX_ASSERT(a_star_in_block, clk, rst, state.star_seen |-> (state.mode == tlex_pkg::MODE_BLOCK), "closing star outside block comment")

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for text_token_lexer_core: random and directed text streams.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 133;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic text_valid = 1'b0;
  logic text_ready;
  tlex_pkg::text_t text_data = '0;
  logic tok_valid;
  logic tok_ready = 1'b0;
  tlex_pkg::tok_t tok_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tlex_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tlex_pkg::MASK_W-1:0] cfg_data = '0;

  tlex_pkg::text_t pending_text[$];
  tlex_pkg::tok_t expected_toks[$];

  // predicted lexer state
  logic [tlex_pkg::MASK_W-1:0] allow_low = '0;
  logic [tlex_pkg::MASK_W-1:0] allow_high = '0;
  logic [tlex_pkg::MODE_W-1:0] lx_mode = tlex_pkg::MODE_BETWEEN;
  logic [7:0] lx_held = '0;
  bit lx_held_ok = 0;
  bit lx_star = 0;

  int send_idle_max = 0;
  int recv_idle_max = 0;
  int send_wait = 0;
  int recv_wait = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int queued_items = 0;

  text_token_lexer_core dut (
    .clk(clk),
    .rst(rst),
    .text_valid(text_valid),
    .text_ready(text_ready),
    .text_data(text_data),
    .tok_valid(tok_valid),
    .tok_ready(tok_ready),
    .tok_data(tok_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic bit joins_word(logic [7:0] b);
    if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h30 && b <= 8'h39))
      return 1'b1;
    if (b == 8'h00 || b[7])
      return 1'b0;
    if (!b[6])
      return allow_low[b[5:0]];
    return allow_high[b[5:0]];
  endfunction

  // classify byte b, nxt is the following byte (zero when none)
  function automatic tlex_pkg::tok_t classify_byte(logic [7:0] b, logic [7:0] nxt);
    tlex_pkg::tok_t t;
    bit fin;
    bit more;
    t = '0;
    t.out_byte = b;
    fin = (nxt == 8'h00);
    if (b == 8'h00) begin
      lx_mode = tlex_pkg::MODE_BETWEEN;
      lx_star = 1'b0;
      return t;
    end
    case (lx_mode)
      tlex_pkg::MODE_BETWEEN: begin
        if (b <= tlex_pkg::CH_SPACE) begin
          lx_mode = tlex_pkg::MODE_BETWEEN;
        end else if (b == tlex_pkg::CH_SLASH && nxt == tlex_pkg::CH_SLASH) begin
          lx_mode = tlex_pkg::MODE_LINE_MARK;
        end else if (b == tlex_pkg::CH_SLASH && nxt == tlex_pkg::CH_STAR) begin
          lx_mode = tlex_pkg::MODE_BLOCK_MARK;
        end else if (b == tlex_pkg::CH_QUOTE) begin
          lx_mode = tlex_pkg::MODE_STRING;
          t.role = tlex_pkg::ROLE_QUOTE;
          t.token_kind = tlex_pkg::KIND_STRING;
          t.token_start = 1'b1;
          t.token_end = fin;
        end else if (joins_word(b)) begin
          more = joins_word(nxt);
          lx_mode = more ? tlex_pkg::MODE_WORD : tlex_pkg::MODE_BETWEEN;
          t.role = tlex_pkg::ROLE_CONTENT;
          t.token_kind = tlex_pkg::KIND_WORD;
          t.token_start = 1'b1;
          t.token_end = !more;
        end else begin
          t.role = tlex_pkg::ROLE_CONTENT;
          t.token_kind = tlex_pkg::KIND_PUNCT;
          t.token_start = 1'b1;
          t.token_end = 1'b1;
        end
      end
      tlex_pkg::MODE_WORD: begin
        more = joins_word(nxt);
        lx_mode = more ? tlex_pkg::MODE_WORD : tlex_pkg::MODE_BETWEEN;
        t.role = tlex_pkg::ROLE_CONTENT;
        t.token_kind = tlex_pkg::KIND_WORD;
        t.token_end = !more;
      end
      tlex_pkg::MODE_STRING: begin
        t.token_kind = tlex_pkg::KIND_STRING;
        if (b == tlex_pkg::CH_QUOTE) begin
          lx_mode = tlex_pkg::MODE_BETWEEN;
          t.role = tlex_pkg::ROLE_QUOTE;
          t.token_end = 1'b1;
        end else if (b == tlex_pkg::CH_BACKSLASH && nxt == tlex_pkg::CH_QUOTE) begin
          lx_mode = tlex_pkg::MODE_ESC_QUOTE;
          t.role = tlex_pkg::ROLE_CONTENT;
        end else begin
          t.role = tlex_pkg::ROLE_CONTENT;
          t.token_end = fin;
        end
      end
      tlex_pkg::MODE_ESC_QUOTE: begin
        lx_mode = tlex_pkg::MODE_STRING;
        t.role = tlex_pkg::ROLE_CONTENT;
        t.token_kind = tlex_pkg::KIND_STRING;
        t.token_end = fin;
      end
      tlex_pkg::MODE_LINE: begin
        if (b == tlex_pkg::CH_NEWLINE)
          lx_mode = tlex_pkg::MODE_BETWEEN;
      end
      tlex_pkg::MODE_BLOCK: begin
        if (lx_star) begin
          lx_star = 1'b0;
          lx_mode = tlex_pkg::MODE_BETWEEN;
        end else if (b == tlex_pkg::CH_STAR && nxt == tlex_pkg::CH_SLASH) begin
          lx_star = 1'b1;
        end
      end
      tlex_pkg::MODE_LINE_MARK: begin
        lx_mode = tlex_pkg::MODE_LINE;
      end
      default: begin
        lx_mode = tlex_pkg::MODE_BLOCK;
      end
    endcase
    return t;
  endfunction

  function automatic void predict_tokens(tlex_pkg::text_t item);
    tlex_pkg::tok_t res[2];
    int n;
    n = 0;
    if (lx_held_ok) begin
      res[n] = classify_byte(lx_held, item.text_byte);
      n++;
    end
    if (item.end_of_text) begin
      res[n] = classify_byte(item.text_byte, 8'h00);
      n++;
      lx_mode = tlex_pkg::MODE_BETWEEN;
      lx_held = '0;
      lx_held_ok = 1'b0;
      lx_star = 1'b0;
    end else begin
      lx_held = item.text_byte;
      lx_held_ok = 1'b1;
    end
    if (n > 0)
      res[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++)
      expected_toks.insert(expected_toks.size(), res[i]);
  endfunction

  function automatic void check_tok(tlex_pkg::tok_t got);
    tlex_pkg::tok_t want;
    if (expected_toks.size() == 0) begin
      if (fail_count < MAX_REPORTS)
        $display("unexpected tok: byte=%h role=%0d kind=%0d st=%0b en=%0b last=%0b",
                 got.out_byte, got.role, got.token_kind, got.token_start, got.token_end,
                 got.last_of_run);
      fail_count++;
      return;
    end
    want = expected_toks.pop_front();
    if (got.out_byte !== want.out_byte || got.role !== want.role ||
        got.token_kind !== want.token_kind || got.token_start !== want.token_start ||
        got.token_end !== want.token_end || got.last_of_run !== want.last_of_run) begin
      if (fail_count < MAX_REPORTS) begin
        $display("tok mismatch: want byte=%h role=%0d kind=%0d st=%0b en=%0b last=%0b",
                 want.out_byte, want.role, want.token_kind, want.token_start,
                 want.token_end, want.last_of_run);
        $display("              got  byte=%h role=%0d kind=%0d st=%0b en=%0b last=%0b",
                 got.out_byte, got.role, got.token_kind, got.token_start,
                 got.token_end, got.last_of_run);
      end
      fail_count++;
    end
  endfunction

  // text driver
  always @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (text_valid && text_ready) begin
        predict_tokens(text_data);
        send_wait = $urandom_range(0, send_idle_max);
      end else if (!text_valid && send_wait > 0) begin
        send_wait--;
      end
      if (!text_valid || text_ready) begin
        if (send_wait == 0 && pending_text.size() != 0) begin
          text_data <= pending_text.pop_front();
          text_valid <= 1'b1;
        end else begin
          text_valid <= 1'b0;
        end
      end
    end
  end

  // token monitor
  always @(posedge clk) begin
    if (rst) begin
      tok_ready <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (tok_valid && tok_ready) begin
        check_tok(tok_data);
        recv_wait = $urandom_range(0, recv_idle_max);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      tok_ready <= (recv_wait == 0 && hold_left == 0);
    end
  end

  task automatic write_mask(input logic [tlex_pkg::CFG_IDX_W-1:0] idx,
                            input logic [tlex_pkg::MASK_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == tlex_pkg::CFG_ALLOWED_LOW)
      allow_low = val;
    else
      allow_high = val;
  endtask

  task automatic write_masks(input logic [tlex_pkg::MASK_W-1:0] lo,
                             input logic [tlex_pkg::MASK_W-1:0] hi);
    write_mask(tlex_pkg::CFG_ALLOWED_LOW, lo);
    write_mask(tlex_pkg::CFG_ALLOWED_HIGH, hi);
  endtask

  task automatic wait_results_done();
    while (pending_text.size() != 0 || text_valid || expected_toks.size() != 0)
      @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_results_done();
    repeat (8) @(posedge clk);
  endtask

  function automatic void push_byte(logic [7:0] b, bit eot);
    tlex_pkg::text_t t;
    t.text_byte = b;
    t.end_of_text = eot;
    pending_text.insert(pending_text.size(), t);
    queued_items++;
  endfunction

  function automatic void push_text(string s, bit close_last);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i], close_last && (i == s.len() - 1));
  endfunction

  // byte b with an occasional random end of text
  function automatic void push_rand_eot(logic [7:0] b);
    push_byte(b, $urandom_range(0, 49) == 0);
  endfunction

  function automatic logic [7:0] word_byte();
    case ($urandom_range(0, 3))
      0: return 8'h61 + 8'($urandom_range(0, 25));
      1: return 8'h41 + 8'($urandom_range(0, 25));
      2: return 8'h30 + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(1, 127));
    endcase
  endfunction

  function automatic void add_fragment();
    int len;
    logic [7:0] b;
    len = $urandom_range(0, 7);
    case ($urandom_range(0, 10))
      0, 1: begin
        for (int i = 0; i <= len; i++)
          push_rand_eot(word_byte());
      end
      2: begin
        for (int i = 0; i <= len % 3; i++)
          push_rand_eot($urandom_range(0, 1) ? tlex_pkg::CH_SPACE : 8'($urandom_range(1, 32)));
      end
      3, 4: begin
        push_rand_eot(tlex_pkg::CH_QUOTE);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 4))
            0: begin
              push_rand_eot(tlex_pkg::CH_BACKSLASH);
              push_rand_eot(tlex_pkg::CH_QUOTE);
            end
            1: push_rand_eot(8'($urandom_range(128, 255)));
            default: begin
              b = 8'($urandom_range(32, 126));
              push_rand_eot(b == tlex_pkg::CH_QUOTE ? tlex_pkg::CH_SPACE : b);
            end
          endcase
        end
        if ($urandom_range(0, 4) != 0)
          push_rand_eot(tlex_pkg::CH_QUOTE);
      end
      5: begin
        push_rand_eot(tlex_pkg::CH_SLASH);
        push_rand_eot(tlex_pkg::CH_SLASH);
        for (int i = 0; i < len; i++) begin
          b = 8'($urandom_range(1, 255));
          push_rand_eot(b == tlex_pkg::CH_NEWLINE ? tlex_pkg::CH_STAR : b);
        end
        push_rand_eot(tlex_pkg::CH_NEWLINE);
      end
      6: begin
        push_rand_eot(tlex_pkg::CH_SLASH);
        push_rand_eot(tlex_pkg::CH_STAR);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 3))
            0: push_rand_eot(tlex_pkg::CH_STAR);
            1: push_rand_eot(tlex_pkg::CH_SLASH);
            default: push_rand_eot(8'($urandom_range(1, 255)));
          endcase
        end
        push_rand_eot(tlex_pkg::CH_STAR);
        push_rand_eot(tlex_pkg::CH_SLASH);
      end
      7: begin
        case ($urandom_range(0, 3))
          0: push_rand_eot(tlex_pkg::CH_SLASH);
          1: push_rand_eot(tlex_pkg::CH_STAR);
          2: push_rand_eot(tlex_pkg::CH_QUOTE);
          default: push_rand_eot(tlex_pkg::CH_BACKSLASH);
        endcase
      end
      8: push_rand_eot($urandom_range(0, 1) ? 8'($urandom_range(33, 126)) :
                                              8'($urandom_range(128, 255)));
      9: push_rand_eot(8'($urandom_range(0, 255)));
      default: begin
        if ($urandom_range(0, 1))
          push_byte(8'h00, 1'b0);
        else
          push_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
  endfunction

  initial begin
    logic [tlex_pkg::MASK_W-1:0] lo;
    logic [tlex_pkg::MASK_W-1:0] hi;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: bits for space, quote, slash, byte 0, underscore, 0x7F
    write_masks(64'h0000_8005_0000_0001, 64'h8000_0000_8000_0000);
    push_text("a/ \"b", 1'b1);
    push_text("//x\n", 1'b0);
    push_text("/*/*/", 1'b1);
    push_byte(tlex_pkg::CH_QUOTE, 1'b0);
    push_byte(tlex_pkg::CH_BACKSLASH, 1'b0);
    push_byte(tlex_pkg::CH_QUOTE, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(tlex_pkg::CH_QUOTE, 1'b1);
    push_byte(8'h5A, 1'b1);
    wait_idle();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin lo = '0; hi = '0; end
        1: begin lo = '1; hi = '1; end
        3: begin lo = 64'h0000_8005_0000_0001; hi = {$urandom, $urandom}; end
        4: begin lo = '0; hi = '1; end
        5: begin lo = '1; hi = '0; end
        default: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
      endcase
      write_masks(lo, hi);
      send_idle_max = (phase % 3 == 0) ? 12 : (phase % 3 == 1) ? 3 : 0;
      recv_idle_max = (phase % 2 == 0) ? 12 : 0;
      if (phase == 5)
        recv_idle_max = 2;
      if (phase == 2)
        hold_requests++;
      queued_items = 0;
      while (queued_items < PHASE_ITEMS) begin
        add_fragment();
        if (phase == 3 && queued_items >= PHASE_ITEMS / 2 &&
            queued_items < PHASE_ITEMS / 2 + 12) begin
          // sender goes quiet until every result is back
          wait_results_done();
          queued_items = PHASE_ITEMS / 2 + 12;
        end
      end
      push_byte(8'($urandom_range(0, 255)), 1'b1);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_toks.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/tlex_pkg.sv
rtl/tlex_step.sv
rtl/text_token_lexer_core.sv
tb/sv/testbench.sv
